[rtl/core/rgbled_pkg.sv]
// Shared types, constants and codes for the RGB LED chain pulse encoder.
package rgbled_pkg;

    localparam int NUM_LEDS   = 24;
    localparam int IDX_W      = 5;
    localparam int WORD_BITS  = 24;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int PHASE_W    = 8;
    localparam int GAP_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 8;

    localparam logic [PHASE_W-1:0] ZERO_HIGH_RST  = 8'd20;
    localparam logic [PHASE_W-1:0] ONE_HIGH_RST   = 8'd40;
    localparam logic [PHASE_W-1:0] BIT_PERIOD_RST = 8'd62;
    localparam logic [GAP_W-1:0]   GAP_RST        = 16'd9000;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_START = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_TICK  = 2'd3
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_HIGH  = 2'd0,
        CFG_ONE_HIGH   = 2'd1,
        CFG_BIT_PERIOD = 2'd2,
        CFG_GAP        = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [PHASE_W-1:0] zero_high_ticks;
        logic [PHASE_W-1:0] one_high_ticks;
        logic [PHASE_W-1:0] bit_period_ticks;
        logic [GAP_W-1:0]   gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic                 wr_en;
        logic [IDX_W-1:0]     wr_idx;
        logic [WORD_BITS-1:0] wr_data;
        logic                 clr;
    } store_req_t;

endpackage

[rtl/core/rgbled_cfg.sv]
// Timing register bank written through the plain configuration port.
module rgbled_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rgbled_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [rgbled_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output rgbled_pkg::cfg_t                    cfg
);

    rgbled_pkg::cfg_t cfg_reg;
    rgbled_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (rgbled_pkg::cfg_index_t'(cfg_addr))
                rgbled_pkg::CFG_ZERO_HIGH:
                    cfg_next.zero_high_ticks = cfg_wdata[rgbled_pkg::PHASE_W-1:0];
                rgbled_pkg::CFG_ONE_HIGH:
                    cfg_next.one_high_ticks = cfg_wdata[rgbled_pkg::PHASE_W-1:0];
                rgbled_pkg::CFG_BIT_PERIOD:
                    cfg_next.bit_period_ticks = cfg_wdata[rgbled_pkg::PHASE_W-1:0];
                rgbled_pkg::CFG_GAP:
                    cfg_next.gap_ticks = cfg_wdata[rgbled_pkg::GAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_high_ticks  <= rgbled_pkg::ZERO_HIGH_RST;
            cfg_reg.one_high_ticks   <= rgbled_pkg::ONE_HIGH_RST;
            cfg_reg.bit_period_ticks <= rgbled_pkg::BIT_PERIOD_RST;
            cfg_reg.gap_ticks        <= rgbled_pkg::GAP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/rgbled_store.sv]
// Pixel colour store with per-entry valid bits; an invalid entry reads as black.
module rgbled_store (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  rgbled_pkg::store_req_t                req,
    input  logic [rgbled_pkg::IDX_W-1:0]          rd_idx,
    output logic [rgbled_pkg::WORD_BITS-1:0]      rd_data
);

    logic [rgbled_pkg::WORD_BITS-1:0] word_reg [rgbled_pkg::NUM_LEDS];
    logic [rgbled_pkg::NUM_LEDS-1:0]  vld_reg;
    logic [rgbled_pkg::NUM_LEDS-1:0]  vld_next;

    always_comb begin
        vld_next = vld_reg;
        if (req.clr) begin
            vld_next = '0;
        end else if (req.wr_en) begin
            vld_next[req.wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            word_reg[req.wr_idx] <= req.wr_data;
        end
    end

    assign rd_data = vld_reg[rd_idx] ? word_reg[rd_idx] : '0;

endmodule

[rtl/core/rgbled_core.sv]
// Request register, frame sequencer and result register of the pulse encoder.
module rgbled_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  rgbled_pkg::cfg_t                      cfg,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [rgbled_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [rgbled_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [rgbled_pkg::M_TDATA_W-1:0]      m_tdata,
    output rgbled_pkg::store_req_t                store_req,
    output logic [rgbled_pkg::IDX_W-1:0]          rd_idx,
    input  logic [rgbled_pkg::WORD_BITS-1:0]      rd_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BITS,
        ST_GAP
    } send_state_t;

    localparam int PW = rgbled_pkg::PHASE_W;
    localparam int GW = rgbled_pkg::GAP_W;
    localparam int IW = rgbled_pkg::IDX_W;
    localparam int BW = rgbled_pkg::BIT_W;

    // request register
    logic                  in_vld_reg, in_vld_next;
    rgbled_pkg::req_type_t in_req_reg;
    logic [IW-1:0]         in_idx_reg;
    logic [7:0]            in_red_reg, in_green_reg, in_blue_reg;

    // sequencer state
    send_state_t    state_reg, state_next;
    logic [IW-1:0]  pix_reg, pix_next;
    logic [BW-1:0]  bit_reg, bit_next;
    logic [PW-1:0]  phase_reg, phase_next;
    logic [GW-1:0]  gap_reg, gap_next;

    // result register
    logic           out_vld_reg, out_vld_next;
    logic           line_reg, line_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic           acc_reg, acc_next;

    logic           s_fire, advance, busy, cur_bit, idx_ok;
    logic [PW-1:0]  period, high;
    logic [PW:0]    phase_inc;
    logic [GW-1:0]  gap_len;
    logic [GW:0]    gap_inc;
    logic [BW:0]    bit_inc;
    logic [IW:0]    pix_inc;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    assign busy    = (state_reg == ST_BITS) || (state_reg == ST_GAP);
    assign idx_ok  = 32'(in_idx_reg) < rgbled_pkg::NUM_LEDS;
    assign rd_idx  = pix_reg;
    assign cur_bit = rd_data[BW'(rgbled_pkg::WORD_BITS - 1) - bit_reg];

    // phase stays below the period, so comparing against the uncapped high
    // time gives the same level as capping it at the period
    assign period    = (cfg.bit_period_ticks == '0) ? PW'(1) : cfg.bit_period_ticks;
    assign high      = cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
    assign phase_inc = {1'b0, phase_reg} + (PW+1)'(1);
    assign gap_len   = (cfg.gap_ticks == '0) ? GW'(1) : cfg.gap_ticks;
    assign gap_inc   = {1'b0, gap_reg} + (GW+1)'(1);
    assign bit_inc   = {1'b0, bit_reg} + (BW+1)'(1);
    assign pix_inc   = {1'b0, pix_reg} + (IW+1)'(1);

    always_comb begin
        store_req.wr_en   = advance && (in_req_reg == rgbled_pkg::REQ_WRITE)
                            && !busy && idx_ok;
        store_req.wr_idx  = in_idx_reg;
        store_req.wr_data = {in_green_reg, in_red_reg, in_blue_reg};
        store_req.clr     = advance && (in_req_reg == rgbled_pkg::REQ_CLEAR) && !busy;
    end

    always_comb begin
        in_vld_next  = in_vld_reg;
        state_next   = state_reg;
        pix_next     = pix_reg;
        bit_next     = bit_reg;
        phase_next   = phase_reg;
        gap_next     = gap_reg;
        out_vld_next = out_vld_reg;
        line_next    = line_reg;
        busy_next    = busy_reg;
        done_next    = done_reg;
        acc_next     = acc_reg;

        if (m_tready) begin
            out_vld_next = 1'b0;
        end
        if (advance) begin
            in_vld_next  = 1'b0;
            out_vld_next = 1'b1;
            line_next    = 1'b0;
            busy_next    = busy;
            done_next    = 1'b0;
            acc_next     = 1'b0;
            case (in_req_reg)
                rgbled_pkg::REQ_WRITE: begin
                    acc_next = !busy && idx_ok;
                end
                rgbled_pkg::REQ_START, rgbled_pkg::REQ_CLEAR: begin
                    if (!busy) begin
                        acc_next   = 1'b1;
                        state_next = ST_BITS;
                        pix_next   = '0;
                        bit_next   = '0;
                        phase_next = '0;
                        gap_next   = '0;
                    end
                end
                rgbled_pkg::REQ_TICK: begin
                    if (state_reg == ST_BITS) begin
                        line_next  = {1'b0, phase_reg} < {1'b0, high};
                        phase_next = phase_inc[PW-1:0];
                        if (phase_inc >= {1'b0, period}) begin
                            phase_next = '0;
                            bit_next   = bit_inc[BW-1:0];
                            if (bit_inc >= (BW+1)'(rgbled_pkg::WORD_BITS)) begin
                                bit_next = '0;
                                pix_next = pix_inc[IW-1:0];
                                if (pix_inc >= (IW+1)'(rgbled_pkg::NUM_LEDS)) begin
                                    pix_next   = '0;
                                    gap_next   = '0;
                                    state_next = ST_GAP;
                                end
                            end
                        end
                    end else if (state_reg == ST_GAP) begin
                        gap_next = gap_inc[GW-1:0];
                        if (gap_inc >= {1'b0, gap_len}) begin
                            gap_next   = '0;
                            state_next = ST_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (s_fire) begin
            in_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= ST_IDLE;
            pix_reg     <= '0;
            bit_reg     <= '0;
            phase_reg   <= '0;
            gap_reg     <= '0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            state_reg   <= state_next;
            pix_reg     <= pix_next;
            bit_reg     <= bit_next;
            phase_reg   <= phase_next;
            gap_reg     <= gap_next;
        end
        if (s_fire) begin
            in_req_reg   <= rgbled_pkg::req_type_t'(s_tuser[1:0]);
            in_idx_reg   <= s_tdata[IW-1:0];
            in_red_reg   <= s_tdata[IW+7:IW];
            in_green_reg <= s_tdata[IW+15:IW+8];
            in_blue_reg  <= s_tdata[IW+23:IW+16];
        end
        line_reg <= line_next;
        busy_reg <= busy_next;
        done_reg <= done_next;
        acc_reg  <= acc_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'b0, acc_reg, done_reg, busy_reg, line_reg};

endmodule

[rtl/core/rgb_led_chain_pulse_encoder.sv]
// Top level: single-wire LED chain pulse encoder, one request per tick.
// A taken request waits in the request register until the result register can take its result.
// Throughput: one request per cycle unless results stall; the request register refills while one waits.
// Each tick request steps the frame sequencer once; a frame takes
//   NUM_LEDS * 24 * bit_period_ticks + gap_ticks tick requests, a zero period or gap counting as one.
// Reset (aresetn low, synchronous): sequencer idle, pipeline empty, all pixels black,
//   timing registers back to 20 / 40 / 62 / 9000.
module rgb_led_chain_pulse_encoder (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // slave request channel
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [4:0] pixel_index, [12:5] red, [20:13] green, [28:21] blue, [31:29] zero
    input  logic [rgbled_pkg::S_TDATA_W-1:0]      s_tdata,
    // [1:0] req_type
    input  logic [rgbled_pkg::S_TUSER_W-1:0]      s_tuser,
    // master result channel
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [0] line_level, [1] busy_res, [2] frame_done, [3] accepted, [7:4] zero
    output logic [rgbled_pkg::M_TDATA_W-1:0]      m_tdata,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [rgbled_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [rgbled_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    rgbled_pkg::cfg_t                 cfg;
    rgbled_pkg::store_req_t           store_req;
    logic [rgbled_pkg::IDX_W-1:0]     rd_idx;
    logic [rgbled_pkg::WORD_BITS-1:0] rd_data;

    // timing registers; to be written only while no frame is running, which the block itself does not enforce
    rgbled_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // colour words, GRB packed; a clear request taken while idle drops every valid bit
    rgbled_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (store_req),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    // request register -> sequencer step -> result register
    rgbled_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .store_req (store_req),
        .rd_idx    (rd_idx),
        .rd_data   (rd_data)
    );

endmodule

[rtl/core/rgbled_checker.sv]
// Port-level checker for the pulse encoder, bound to the top level.
module rgbled_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [rgbled_pkg::M_TDATA_W-1:0]      m_tdata
);

    // a driven-high line only happens mid-frame
    a_line_needs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[0] || m_tdata[1]))
        else $error("line high outside a frame");

    // a taken request always found the block idle, and never ends a frame
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[3] || (!m_tdata[1] && !m_tdata[2])))
        else $error("request accepted while busy or with frame_done");

    // frame end is reported only by a tick that arrived mid-frame
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[2] || m_tdata[1]))
        else $error("frame_done without busy");

    // nothing comes out the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind rgb_led_chain_pulse_encoder rgbled_checker u_rgbled_checker (.*);

[tb/sv/rgb_led_chain_pulse_encoder_test.sv]
// Self-checking testbench for the RGB LED chain pulse encoder: directed table plus random frames.
module rgb_led_chain_pulse_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Stimulus volume and watchdog
    localparam int RANDOM_ITEMS = 1500;
    localparam int LONG_HOLD    = 300;   // one long receiver hold-off, in cycles
    localparam int STALL_LIMIT  = 3000;  // cycles with no handshake before giving up
    localparam int SETTLE       = 8;     // quiet cycles after the last result

    // Result fields as they sit in m_tdata[3:0], lowest bit last here
    typedef struct packed {
        logic accepted;
        logic frame_done;
        logic busy;
        logic line;
    } led_result_t;

    // Sequencer state of the shadow model
    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_BITS = 2'd1,
        SEQ_GAP  = 2'd2
    } seq_state_t;

    // One row of the directed table; want is only used where typed is set
    typedef struct packed {
        rgbled_pkg::req_type_t        req;
        logic [rgbled_pkg::IDX_W-1:0] idx;
        logic [7:0]                   red;
        logic [7:0]                   green;
        logic [7:0]                   blue;
        logic                         typed;
        led_result_t                  want;
    } stim_row_t;

    logic                              aclk;
    logic                              aresetn   = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [rgbled_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic [rgbled_pkg::S_TUSER_W-1:0]  s_tuser   = '0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [rgbled_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                              cfg_wr_en = 1'b0;
    logic [rgbled_pkg::CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [rgbled_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow model of the block
    logic [rgbled_pkg::WORD_BITS-1:0]  led_colour [rgbled_pkg::NUM_LEDS];
    int                                chain_pos;
    int                                bit_pos;
    int                                phase_cnt;
    int                                gap_cnt;
    seq_state_t                        seq;
    rgbled_pkg::cfg_t                  timing;

    // Results owed by the block, oldest first
    led_result_t           due_results [$];

    int                    mismatches   = 0;
    int                    results_seen = 0;
    int                    items_sent   = 0;
    int                    idle_cycles  = 0;
    int                    source_calm  = 0;
    int                    sink_calm    = 0;
    bit                    hold_pending = 1'b0;

    rgb_led_chain_pulse_encoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Directed rows. want reads {accepted, frame_done, busy, line}.
    // Timing in force: zero high 0, one high 1, period 1, gap 0, so a one bit
    // drives the line high for its single tick and a zero bit leaves it low.
    stim_row_t directed_rows [13] = '{
        // tick with nothing to send: line low, nothing taken
        '{rgbled_pkg::REQ_TICK,  5'd31, 8'hFF, 8'hFF, 8'hFF, 1'b1, 4'b0000},
        // pixel writes at both ends of the chain, all ones and all zeros
        '{rgbled_pkg::REQ_WRITE, 5'd0,  8'hFF, 8'hFF, 8'hFF, 1'b1, 4'b1000},
        '{rgbled_pkg::REQ_WRITE, 5'd23, 8'h00, 8'h00, 8'h00, 1'b1, 4'b1000},
        // index past the chain is refused
        '{rgbled_pkg::REQ_WRITE, 5'd24, 8'h12, 8'h34, 8'h56, 1'b1, 4'b0000},
        '{rgbled_pkg::REQ_WRITE, 5'd31, 8'hFF, 8'hFF, 8'hFF, 1'b1, 4'b0000},
        '{rgbled_pkg::REQ_WRITE, 5'd5,  8'h80, 8'h01, 8'h7F, 1'b1, 4'b1000},
        // frame start taken while idle
        '{rgbled_pkg::REQ_START, 5'd0,  8'h00, 8'h00, 8'h00, 1'b1, 4'b1000},
        // first bit of LED 0 is a one: line high, now busy
        '{rgbled_pkg::REQ_TICK,  5'd0,  8'h00, 8'h00, 8'h00, 1'b1, 4'b0011},
        // writes, starts and clears are all refused mid-frame
        '{rgbled_pkg::REQ_WRITE, 5'd1,  8'hAA, 8'h55, 8'hAA, 1'b1, 4'b0010},
        '{rgbled_pkg::REQ_START, 5'd0,  8'h00, 8'h00, 8'h00, 1'b1, 4'b0010},
        '{rgbled_pkg::REQ_CLEAR, 5'd0,  8'h00, 8'h00, 8'h00, 1'b1, 4'b0010},
        '{rgbled_pkg::REQ_TICK,  5'd0,  8'h00, 8'h00, 8'h00, 1'b1, 4'b0011},
        '{rgbled_pkg::REQ_TICK,  5'd7,  8'h5A, 8'hA5, 8'h3C, 1'b0, 4'b0000}
    };

    // Shadow model: advances on one accepted request, returns what the block owes
    function automatic led_result_t step_chain(input rgbled_pkg::req_type_t req,
                                               input logic [rgbled_pkg::IDX_W-1:0] idx,
                                               input logic [7:0] red,
                                               input logic [7:0] green,
                                               input logic [7:0] blue);
        led_result_t res;
        int          period;
        int          high;
        int          gap_len;
        logic        bit_val;
        res      = '0;
        res.busy = (seq == SEQ_BITS) || (seq == SEQ_GAP);
        case (req)
            rgbled_pkg::REQ_WRITE: begin
                if (!res.busy && idx < rgbled_pkg::NUM_LEDS) begin
                    led_colour[idx] = {green, red, blue};
                    res.accepted    = 1'b1;
                end
            end
            rgbled_pkg::REQ_START, rgbled_pkg::REQ_CLEAR: begin
                if (!res.busy) begin
                    if (req == rgbled_pkg::REQ_CLEAR) begin
                        foreach (led_colour[i]) led_colour[i] = '0;
                    end
                    chain_pos    = 0;
                    bit_pos      = 0;
                    phase_cnt    = 0;
                    gap_cnt      = 0;
                    seq          = SEQ_BITS;
                    res.accepted = 1'b1;
                end
            end
            default: begin
                if (seq == SEQ_BITS) begin
                    // zero period counts as one; high time capped at the period
                    period  = (timing.bit_period_ticks == 0) ? 1 : int'(timing.bit_period_ticks);
                    bit_val = led_colour[chain_pos][rgbled_pkg::WORD_BITS-1-bit_pos];
                    high    = bit_val ? int'(timing.one_high_ticks)
                                      : int'(timing.zero_high_ticks);
                    if (high > period) high = period;
                    res.line = (phase_cnt < high);
                    phase_cnt++;
                    if (phase_cnt >= period) begin
                        phase_cnt = 0;
                        bit_pos++;
                        if (bit_pos >= rgbled_pkg::WORD_BITS) begin
                            bit_pos = 0;
                            chain_pos++;
                            if (chain_pos >= rgbled_pkg::NUM_LEDS) begin
                                chain_pos = 0;
                                gap_cnt   = 0;
                                seq       = SEQ_GAP;
                            end
                        end
                    end
                end else if (seq == SEQ_GAP) begin
                    gap_len = (timing.gap_ticks == 0) ? 1 : int'(timing.gap_ticks);
                    gap_cnt++;
                    if (gap_cnt >= gap_len) begin
                        gap_cnt        = 0;
                        seq            = SEQ_IDLE;
                        res.frame_done = 1'b1;
                    end
                end
            end
        endcase
        return res;
    endfunction

    // Idle cycles before the next request or result; runs of zero now and then
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 6));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH result %0d %s: got %0d expected %0d",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    // Offer one request and wait for the handshake; the expectation is filed at acceptance
    task automatic push_request(input rgbled_pkg::req_type_t req,
                                input logic [rgbled_pkg::IDX_W-1:0] idx,
                                input logic [7:0] red, input logic [7:0] green,
                                input logic [7:0] blue, input bit typed = 1'b0,
                                input led_result_t want = '0);
        int          gap_cycles;
        led_result_t predicted;
        gap_cycles = draw_wait(source_calm);
        if (gap_cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap_cycles) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {3'b000, blue, green, red, idx};
        do @(posedge aclk); while (!s_tready);
        predicted = step_chain(req, idx, red, green, blue);
        due_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic offer_write();
        logic [rgbled_pkg::IDX_W-1:0] idx;
        // mostly inside the chain, sometimes past its end
        idx = ($urandom_range(0, 6) == 0)
              ? rgbled_pkg::IDX_W'($urandom_range(rgbled_pkg::NUM_LEDS, 31))
              : rgbled_pkg::IDX_W'($urandom_range(0, rgbled_pkg::NUM_LEDS-1));
        push_request(rgbled_pkg::REQ_WRITE, idx, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic offer_tick();
        push_request(rgbled_pkg::REQ_TICK, rgbled_pkg::IDX_W'($urandom_range(0, 31)),
                     8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Request that is refused while a frame is running
    task automatic offer_noise();
        case ($urandom_range(0, 2))
            0:       offer_write();
            1:       push_request(rgbled_pkg::REQ_START, rgbled_pkg::IDX_W'($urandom),
                                  8'($urandom), 8'($urandom), 8'($urandom));
            default: push_request(rgbled_pkg::REQ_CLEAR, rgbled_pkg::IDX_W'($urandom),
                                  8'($urandom), 8'($urandom), 8'($urandom));
        endcase
    endtask

    // Tick the running frame through its bits and gap, with refused requests mixed in
    task automatic run_to_idle();
        while (seq != SEQ_IDLE) begin
            if ($urandom_range(0, 15) == 0) offer_noise();
            else offer_tick();
        end
        repeat ($urandom_range(0, 3)) offer_tick();
    endtask

    // A well-formed frame: some pixel writes and idle ticks, a start or clear, then ticks to the end
    task automatic play_frame();
        repeat ($urandom_range(0, 12)) begin
            if ($urandom_range(0, 4) == 0) offer_tick();
            else offer_write();
        end
        push_request(($urandom_range(0, 3) == 0) ? rgbled_pkg::REQ_CLEAR
                                                 : rgbled_pkg::REQ_START,
                     rgbled_pkg::IDX_W'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
        run_to_idle();
    endtask

    // Stop offering and wait until the block owes nothing
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input rgbled_pkg::cfg_index_t which,
                             input logic [rgbled_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= which;
        cfg_wdata <= value;
        @(posedge aclk);
        case (which)
            rgbled_pkg::CFG_ZERO_HIGH:
                timing.zero_high_ticks  = value[rgbled_pkg::PHASE_W-1:0];
            rgbled_pkg::CFG_ONE_HIGH:
                timing.one_high_ticks   = value[rgbled_pkg::PHASE_W-1:0];
            rgbled_pkg::CFG_BIT_PERIOD:
                timing.bit_period_ticks = value[rgbled_pkg::PHASE_W-1:0];
            default:
                timing.gap_ticks        = value;
        endcase
    endtask

    // Timing registers are only touched with the block idle and nothing in flight
    task automatic apply_timing(input logic [7:0] zero_high, input logic [7:0] one_high,
                                input logic [7:0] period, input logic [15:0] gap);
        drain_results();
        write_reg(rgbled_pkg::CFG_ZERO_HIGH,  {8'h00, zero_high});
        write_reg(rgbled_pkg::CFG_ONE_HIGH,   {8'h00, one_high});
        write_reg(rgbled_pkg::CFG_BIT_PERIOD, {8'h00, period});
        write_reg(rgbled_pkg::CFG_GAP,        gap);
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: random back-pressure, one long hold-off on request
    initial begin : result_sink
        int          stall;
        led_result_t got;
        led_result_t want;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_pending) begin
                stall        = LONG_HOLD;
                hold_pending = 1'b0;
            end else begin
                stall = draw_wait(sink_calm);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = led_result_t'(m_tdata[3:0]);
            results_seen++;
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result", int'(got), 0);
            end else begin
                want = due_results.pop_front();
                if (got.line !== want.line)
                    report_mismatch("line_level", int'(got.line), int'(want.line));
                if (got.busy !== want.busy)
                    report_mismatch("busy_res", int'(got.busy), int'(want.busy));
                if (got.frame_done !== want.frame_done)
                    report_mismatch("frame_done", int'(got.frame_done), int'(want.frame_done));
                if (got.accepted !== want.accepted)
                    report_mismatch("accepted", int'(got.accepted), int'(want.accepted));
            end
        end
    end

    // Watchdog: a long run of cycles with neither channel moving means a hang
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int phase;
        // shadow model starts from the reset state
        foreach (led_colour[i]) led_colour[i] = '0;
        chain_pos = 0;
        bit_pos   = 0;
        phase_cnt = 0;
        gap_cnt   = 0;
        seq       = SEQ_IDLE;
        timing    = '{rgbled_pkg::ZERO_HIGH_RST, rgbled_pkg::ONE_HIGH_RST,
                      rgbled_pkg::BIT_PERIOD_RST, rgbled_pkg::GAP_RST};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Shortest frame that still tells a one from a zero; zero gap counts as one tick
        apply_timing(8'd0, 8'd1, 8'd1, 16'd0);

        foreach (directed_rows[i])
            push_request(directed_rows[i].req, directed_rows[i].idx, directed_rows[i].red,
                         directed_rows[i].green, directed_rows[i].blue,
                         directed_rows[i].typed, directed_rows[i].want);

        // Finish the directed frame while the receiver stops for a long stretch,
        // so the block fills up and pushes back on the request side
        hold_pending = 1'b1;
        run_to_idle();

        phase = 1;
        while (items_sent < $size(directed_rows) + RANDOM_ITEMS) begin
            case (phase)
                // zero period read as one; one bits stay low, zero bits go high
                1:       apply_timing(8'd1, 8'd0, 8'd0, 16'd2);
                // high time past the period is capped
                2:       apply_timing(8'd0, 8'd255, 8'd1, 16'd3);
                default: apply_timing(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                                      8'($urandom_range(0, 2)), 16'($urandom_range(0, 20)));
            endcase
            play_frame();
            phase++;
        end

        // Widest settings last: a full frame here would be far too long, so it is
        // only run for about a hundred ticks and left in flight at the end
        apply_timing(8'd255, 8'd1, 8'd255, 16'hFFFF);
        repeat (4) offer_write();
        push_request(rgbled_pkg::REQ_START, rgbled_pkg::IDX_W'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
        repeat (100) begin
            if ($urandom_range(0, 15) == 0) offer_noise();
            else offer_tick();
        end

        drain_results();
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
